@@ rtl/wis_pkg.sv @@
// Shared constants, codes and types for the weighted index sampler.
package wis_pkg;

  // Table size and arithmetic widths.
  localparam int CAPACITY_N  = 4096;
  localparam int WEIGHT_BITS = 32;
  localparam int ADDR_W      = $clog2(CAPACITY_N);
  localparam int COUNT_W     = ADDR_W + 1;
  localparam int SUM_W       = WEIGHT_BITS - 1 + COUNT_W;
  localparam int FRAC_W      = 32;
  localparam int HI_W        = SUM_W - FRAC_W;
  localparam int DIV_STEPS   = SUM_W;
  localparam int DIVCNT_W    = $clog2(DIV_STEPS);

  localparam logic [COUNT_W-1:0] CAPACITY = COUNT_W'(CAPACITY_N);

  // Input transaction kinds.
  localparam logic [1:0] KIND_LOAD   = 2'd0;
  localparam logic [1:0] KIND_ARM    = 2'd1;
  localparam logic [1:0] KIND_DRAW   = 2'd2;
  localparam logic [1:0] KIND_REWIND = 2'd3;

  // Result status codes.
  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_EMPTY    = 2'd1;
  localparam logic [1:0] STAT_CAP      = 2'd2;
  localparam logic [1:0] STAT_DISABLED = 2'd3;

  // Configuration register indexes.
  localparam logic CFG_SAMPLING_ENABLE = 1'b0;
  localparam logic CFG_CAP_ENTRIES     = 1'b1;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_MUL,
    ST_ADD,
    ST_SRCH_RD,
    ST_SRCH_CMP,
    ST_SEQ,
    ST_EMIT
  } state_t;

endpackage

@@ rtl/weighted_index_sampler.sv @@
// Weighted index sampler: weight table, prefix sums, arm divider and binary search.
// Load, rewind, empty arm and end of pass go straight to the result; a sequential draw
// reads the weight table first; arm forms one quotient bit per cycle (44-bit total).
// A weighted draw scales the fraction by the total, then runs a binary search that
// reads one prefix memory entry and compares it with the target at each step.
// One transaction is processed at a time; a finished result waits in the output register.
// Reset (synchronous, active high) clears all control state; table memories are not cleared.
module weighted_index_sampler (
  input  logic        clk,
  input  logic        rst,
  // Configuration write port.
  input  logic        cfg_we,
  input  logic        cfg_addr,
  input  logic [12:0] cfg_wdata,
  // Input stream.
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // weight_in [31:0], random_fraction [63:32]
  input  logic [1:0]  s_tuser,   // kind [1:0]
  // Output stream.
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata    // status [1:0], entry_index [13:2], weight_out [45:14],
                                 // pass_wrapped [46], zero [47]
);

  // Configuration and control state.
  logic                            sampling_enable;
  logic [wis_pkg::COUNT_W-1:0]     cap_entries;
  logic [wis_pkg::COUNT_W-1:0]     entry_count;
  logic [wis_pkg::SUM_W-1:0]       run_sum;
  logic [wis_pkg::SUM_W-1:0]       total_weight;
  logic [wis_pkg::WEIGHT_BITS-1:0] mean_weight;
  logic [wis_pkg::COUNT_W-1:0]     read_position;
  logic [wis_pkg::ADDR_W-1:0]      draw_modulo;
  logic                            armed;
  logic                            active;
  logic                            closed;

  wis_pkg::state_t state, state_next;

  // Working registers.
  logic [wis_pkg::FRAC_W-1:0]          frac_q;
  logic [2*wis_pkg::FRAC_W-1:0]        prod_lo;
  logic [wis_pkg::SUM_W-1:0]           prod_hi;
  logic [wis_pkg::SUM_W-1:0]           target;
  logic [wis_pkg::COUNT_W-1:0]         srch_a;
  logic [wis_pkg::COUNT_W-1:0]         srch_b;
  logic [wis_pkg::ADDR_W-1:0]          div_rem;
  logic [wis_pkg::SUM_W-1:0]           div_quo;
  logic [wis_pkg::DIVCNT_W-1:0]        div_cnt;

  // Pending result.
  logic [1:0]                      res_status;
  logic [wis_pkg::ADDR_W-1:0]      res_index;
  logic [wis_pkg::WEIGHT_BITS-1:0] res_weight;
  logic                            res_wrap;

  // Memories and their read data.
  logic [wis_pkg::WEIGHT_BITS-1:0] weight_mem [wis_pkg::CAPACITY_N];
  logic [wis_pkg::SUM_W-1:0]       prefix_mem [wis_pkg::CAPACITY_N];
  logic [wis_pkg::WEIGHT_BITS-1:0] wt_rd;
  logic [wis_pkg::SUM_W-1:0]       pf_rd;

  // Input fields.
  logic [1:0]                      kind;
  logic [wis_pkg::WEIGHT_BITS-1:0] weight_in;
  logic [wis_pkg::FRAC_W-1:0]      random_fraction;

  assign kind            = s_tuser;
  assign weight_in       = s_tdata[31:0];
  assign random_fraction = s_tdata[63:32];

  // Handshake and decode.
  logic in_acc;
  logic out_free;
  logic sample_on;
  logic load_wr;
  assign s_tready  = (state == wis_pkg::ST_IDLE);
  assign in_acc    = s_tvalid & s_tready;
  assign out_free  = !m_tvalid || m_tready;
  assign sample_on = armed && active && (entry_count != '0);

  // Cap check for a load.
  logic [wis_pkg::COUNT_W-1:0] entry_limit;
  logic                        load_full;
  logic [wis_pkg::SUM_W-1:0]   load_add;
  assign entry_limit = (cap_entries == '0 || cap_entries > wis_pkg::CAPACITY) ?
                       wis_pkg::CAPACITY : cap_entries;
  assign load_full   = ({1'b0, entry_count} + (wis_pkg::COUNT_W+1)'(1)) >
                       {1'b0, entry_limit};
  assign load_add    = weight_in[wis_pkg::WEIGHT_BITS-1] ? '0 :
                       wis_pkg::SUM_W'(weight_in[wis_pkg::WEIGHT_BITS-2:0]);
  assign load_wr     = in_acc && (kind == wis_pkg::KIND_LOAD) && !closed && !load_full;

  // Binary search midpoint.
  logic [wis_pkg::COUNT_W-1:0] srch_mid;
  logic                        srch_more;
  assign srch_mid  = srch_a + ((srch_b - srch_a) >> 1);
  assign srch_more = srch_a < srch_b;

  // Search result clamp and pass counter.
  logic [wis_pkg::COUNT_W-1:0] srch_idx;
  logic [wis_pkg::COUNT_W-1:0] dm_inc;
  logic                        dm_wrap;
  assign srch_idx = (srch_a >= entry_count) ? entry_count - wis_pkg::COUNT_W'(1) : srch_a;
  assign dm_inc   = wis_pkg::COUNT_W'(draw_modulo) + wis_pkg::COUNT_W'(1);
  assign dm_wrap  = (dm_inc == entry_count);

  // Restoring divider step.
  logic [wis_pkg::ADDR_W:0]   div_trial;
  logic                       div_ge;
  logic [wis_pkg::ADDR_W-1:0] div_rem_next;
  logic [wis_pkg::SUM_W-1:0]  div_quo_next;
  assign div_trial    = {div_rem, div_quo[wis_pkg::SUM_W-1]};
  assign div_ge       = div_trial >= entry_count;
  assign div_rem_next = div_ge ? wis_pkg::ADDR_W'(div_trial - entry_count) :
                                 div_trial[wis_pkg::ADDR_W-1:0];
  assign div_quo_next = {div_quo[wis_pkg::SUM_W-2:0], div_ge};

  // Weight memory: written on load, read at the sequential read position.
  always_ff @(posedge clk) begin
    if (load_wr) begin
      weight_mem[entry_count[wis_pkg::ADDR_W-1:0]] <= weight_in;
    end
    wt_rd <= weight_mem[read_position[wis_pkg::ADDR_W-1:0]];
  end

  // Prefix memory: written on load, read at the search midpoint.
  always_ff @(posedge clk) begin
    if (load_wr) begin
      prefix_mem[entry_count[wis_pkg::ADDR_W-1:0]] <= run_sum + load_add;
    end
    if (state == wis_pkg::ST_SRCH_RD) begin
      pf_rd <= prefix_mem[srch_mid[wis_pkg::ADDR_W-1:0]];
    end
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= wis_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      wis_pkg::ST_IDLE: begin
        if (in_acc) begin
          case (kind)
            wis_pkg::KIND_ARM: begin
              state_next = (entry_count == '0) ? wis_pkg::ST_EMIT : wis_pkg::ST_DIV;
            end
            wis_pkg::KIND_DRAW: begin
              if (sample_on) begin
                state_next = wis_pkg::ST_MUL;
              end else if (read_position >= entry_count) begin
                state_next = wis_pkg::ST_EMIT;
              end else begin
                state_next = wis_pkg::ST_SEQ;
              end
            end
            default: state_next = wis_pkg::ST_EMIT;
          endcase
        end
      end
      wis_pkg::ST_DIV: begin
        if (div_cnt == wis_pkg::DIVCNT_W'(wis_pkg::DIV_STEPS - 1)) begin
          state_next = wis_pkg::ST_EMIT;
        end
      end
      wis_pkg::ST_MUL:      state_next = wis_pkg::ST_ADD;
      wis_pkg::ST_ADD:      state_next = wis_pkg::ST_SRCH_RD;
      wis_pkg::ST_SRCH_RD:  state_next = srch_more ? wis_pkg::ST_SRCH_CMP : wis_pkg::ST_EMIT;
      wis_pkg::ST_SRCH_CMP: state_next = wis_pkg::ST_SRCH_RD;
      wis_pkg::ST_SEQ:      state_next = wis_pkg::ST_EMIT;
      wis_pkg::ST_EMIT: begin
        if (out_free) begin
          state_next = wis_pkg::ST_IDLE;
        end
      end
      default: state_next = wis_pkg::ST_IDLE;
    endcase
  end

  // Datapath and table control.
  always_ff @(posedge clk) begin
    if (rst) begin
      sampling_enable <= 1'b1;
      cap_entries     <= '0;
      entry_count     <= '0;
      run_sum         <= '0;
      total_weight    <= '0;
      mean_weight     <= '0;
      read_position   <= '0;
      draw_modulo     <= '0;
      armed           <= 1'b0;
      active          <= 1'b1;
      closed          <= 1'b0;
    end else begin
      case (state)
        wis_pkg::ST_IDLE: begin
          if (in_acc) begin
            res_status <= wis_pkg::STAT_OK;
            res_index  <= '0;
            res_weight <= '0;
            res_wrap   <= 1'b0;
            frac_q     <= random_fraction;
            case (kind)
              wis_pkg::KIND_LOAD: begin
                if (closed) begin
                  res_status <= wis_pkg::STAT_CAP;
                end else if (load_full) begin
                  entry_count   <= '0;
                  read_position <= '0;
                  draw_modulo   <= '0;
                  run_sum       <= '0;
                  total_weight  <= '0;
                  mean_weight   <= '0;
                  armed         <= 1'b0;
                  active        <= 1'b0;
                  closed        <= 1'b1;
                  res_status    <= wis_pkg::STAT_CAP;
                end else begin
                  run_sum     <= run_sum + load_add;
                  armed       <= 1'b0;
                  entry_count <= entry_count + wis_pkg::COUNT_W'(1);
                  res_index   <= entry_count[wis_pkg::ADDR_W-1:0];
                  res_weight  <= weight_in;
                end
              end
              wis_pkg::KIND_ARM: begin
                if (entry_count == '0) begin
                  armed      <= 1'b0;
                  res_status <= wis_pkg::STAT_EMPTY;
                end else begin
                  total_weight  <= run_sum;
                  read_position <= '0;
                  draw_modulo   <= '0;
                  armed         <= 1'b1;
                  active        <= sampling_enable && (run_sum != '0);
                  if (sampling_enable && run_sum == '0) begin
                    res_status <= wis_pkg::STAT_DISABLED;
                  end
                  div_rem <= '0;
                  div_quo <= run_sum;
                  div_cnt <= '0;
                end
              end
              wis_pkg::KIND_DRAW: begin
                if (!sample_on && read_position >= entry_count) begin
                  res_status <= wis_pkg::STAT_EMPTY;
                end
              end
              default: begin
                read_position <= '0;
              end
            endcase
          end
        end
        // One quotient bit per cycle; the last step yields the mean.
        wis_pkg::ST_DIV: begin
          div_rem <= div_rem_next;
          div_quo <= div_quo_next;
          div_cnt <= div_cnt + wis_pkg::DIVCNT_W'(1);
          if (div_cnt == wis_pkg::DIVCNT_W'(wis_pkg::DIV_STEPS - 1)) begin
            mean_weight <= div_quo_next[wis_pkg::WEIGHT_BITS-1:0];
            res_weight  <= div_quo_next[wis_pkg::WEIGHT_BITS-1:0];
          end
        end
        // Scale the fraction by the total as two partial products.
        wis_pkg::ST_MUL: begin
          prod_lo <= total_weight[wis_pkg::FRAC_W-1:0] * frac_q;
          prod_hi <= wis_pkg::SUM_W'(total_weight[wis_pkg::SUM_W-1:wis_pkg::FRAC_W] * frac_q);
        end
        wis_pkg::ST_ADD: begin
          target <= prod_hi + wis_pkg::SUM_W'(prod_lo[2*wis_pkg::FRAC_W-1:wis_pkg::FRAC_W]);
          srch_a <= '0;
          srch_b <= entry_count;
        end
        // Search ends: clamp the index and advance the pass counter.
        wis_pkg::ST_SRCH_RD: begin
          if (!srch_more) begin
            res_index   <= srch_idx[wis_pkg::ADDR_W-1:0];
            res_weight  <= mean_weight;
            res_wrap    <= dm_wrap;
            draw_modulo <= dm_wrap ? '0 : dm_inc[wis_pkg::ADDR_W-1:0];
          end
        end
        // Narrow the search range on the prefix sum at the midpoint.
        wis_pkg::ST_SRCH_CMP: begin
          if (pf_rd > target) begin
            srch_b <= srch_mid;
          end else begin
            srch_a <= srch_mid + wis_pkg::COUNT_W'(1);
          end
        end
        wis_pkg::ST_SEQ: begin
          res_index     <= read_position[wis_pkg::ADDR_W-1:0];
          res_weight    <= wt_rd;
          read_position <= read_position + wis_pkg::COUNT_W'(1);
        end
        default: begin
        end
      endcase

      // The user must write configuration only while the block is idle; the block does not enforce it.
      if (cfg_we) begin
        case (cfg_addr)
          wis_pkg::CFG_SAMPLING_ENABLE: begin
            sampling_enable <= cfg_wdata[0];
            active          <= cfg_wdata[0];
          end
          default: begin
            cap_entries <= cfg_wdata;
          end
        endcase
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == wis_pkg::ST_EMIT && out_free) begin
      m_tvalid <= 1'b1;
      m_tdata  <= {1'b0, res_wrap, res_weight, res_index, res_status};
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // The pass counter stays below the entry count while weighted draws are enabled.
  assert property (@(posedge clk) disable iff (rst)
    armed && active |-> ({1'b0, draw_modulo} < entry_count))
    else $error("draw counter out of range");

  // The sequential read position never passes the end of the table.
  assert property (@(posedge clk) disable iff (rst)
    read_position <= entry_count)
    else $error("read position past end of table");

  // The divider remainder stays below the divisor.
  assert property (@(posedge clk) disable iff (rst)
    state == wis_pkg::ST_DIV |-> ({1'b0, div_rem} < entry_count))
    else $error("divider remainder out of range");

  // The search window stays ordered and inside the table.
  assert property (@(posedge clk) disable iff (rst)
    state == wis_pkg::ST_SRCH_RD |-> (srch_a <= srch_b) && (srch_b <= entry_count))
    else $error("search window out of range");

  // A closed table stays empty and unarmed.
  assert property (@(posedge clk) disable iff (rst)
    closed |-> (entry_count == '0) && !armed)
    else $error("closed table holds entries");

endmodule
